// ===== rtl/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and helpers for the page table walker
// Request/result payload structs, kind codes and the per-level address math
// for a radix page table with the Sv39 entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  localparam int unsigned VA_W       = 39;
  localparam int unsigned PA_W       = 56;
  localparam int unsigned PTE_W      = 64;
  localparam int unsigned LVL_W      = 2;
  localparam int unsigned SHIFT_W    = 6;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned VPN_BITS   = 9;
  localparam int unsigned PPN_LSB    = 10;
  localparam int unsigned PPN_W      = 44;

  localparam int unsigned LEVELS_DEF         = 3;
  localparam int unsigned PHYS_ADDR_BITS_DEF = 56;

  // PTE flag bit positions
  localparam int unsigned PTE_V = 0;
  localparam int unsigned PTE_R = 1;
  localparam int unsigned PTE_W_BIT = 2;
  localparam int unsigned PTE_X = 3;

  typedef enum logic {
    KIND_TRANSLATE = 1'b0,
    KIND_ENTRY     = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    RES_READ  = 2'd0,
    RES_DONE  = 2'd1,
    RES_FAULT = 2'd2
  } result_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [VA_W-1:0]   virtual_address;
    logic [PTE_W-1:0]  entry_data;
  } ptw_req_t;

  typedef struct packed {
    result_kind_t      result_kind;
    logic [PA_W-1:0]   physical_address;
    logic [LVL_W-1:0]  fault_level;
  } ptw_res_t;

  // Bit position of the VPN field for a level (0 = top)
  function automatic logic [SHIFT_W-1:0] level_shift(input int unsigned levels,
                                                     input logic [LVL_W-1:0] lvl);
    level_shift = SHIFT_W'(PAGE_SHIFT + VPN_BITS * (levels - 1 - 32'(lvl)));
  endfunction

  // Entry address: page-aligned table base plus VPN index times 8
  function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0]    base,
                                                 input logic [VA_W-1:0]    va,
                                                 input logic [SHIFT_W-1:0] shift);
    logic [VPN_BITS-1:0] idx;
    idx = VPN_BITS'(va >> shift);
    entry_addr = {base[PA_W-1:PAGE_SHIFT], idx, 3'b000};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/three_level_page_table_walker.sv =====
// out_valid is registered: an accepted request passes the input register, then
//   the result register; one request per cycle while the output is not stalled.
// Each returned entry is decoded by shift/mask logic in one pass, so the walk
//   rate is set by the external memory latency, not by this block.
// Reset (synchronous, rst_n low) clears the walk state, root base and valids.
// ----------------------------------------------------------------------------
// three_level_page_table_walker: radix page table walker, Sv39 entry layout
// Takes translate requests and returned entries, issues entry reads and
// reports the translated address or the level of an invalid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_page_table_walker
  import ptw_pkg::*;
#(
  parameter int unsigned LEVELS         = LEVELS_DEF,
  parameter int unsigned PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_stall,
  input  wire ptw_req_t        in_data,
  output      logic            out_valid,
  input  wire logic            out_stall,
  output      ptw_res_t        out_data,
  input  wire logic            cfg_valid,
  output      logic            cfg_ready,
  input  wire logic [PA_W-1:0] cfg_data
);

  localparam logic [PA_W-1:0]  PA_MASK   = {PA_W{1'b1}} >> (PA_W - PHYS_ADDR_BITS);
  localparam logic [LVL_W-1:0] LAST_LVL  = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0] TOP_LVL   = '0;

  logic             req_valid_r, req_valid_nxt;
  ptw_req_t         req_r;
  logic             out_valid_r, out_valid_nxt;
  ptw_res_t         out_data_r, out_data_nxt;
  logic [PA_W-1:0]  root_base_r, root_base_nxt;
  logic [LVL_W-1:0] walk_level_r, walk_level_nxt;
  logic [VA_W-1:0]  held_virtual_address_r, held_virtual_address_nxt;
  logic             walk_busy_r, walk_busy_nxt;

  logic             out_free;
  logic             advance;
  logic             in_accept;
  logic             produce;
  ptw_res_t         res;
  logic [PA_W-1:0]  ppn_base;
  logic [PA_W-1:0]  low_mask;
  logic [SHIFT_W-1:0] cur_shift;
  logic [LVL_W-1:0] next_level;
  logic             is_leaf;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = req_valid_r && out_free;
  assign in_stall  = req_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = !req_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ppn_base   = PA_W'({req_r.entry_data[PPN_LSB +: PPN_W], {PAGE_SHIFT{1'b0}}});
  assign cur_shift  = level_shift(LEVELS, walk_level_r);
  assign low_mask   = (PA_W'(1) << cur_shift) - PA_W'(1);
  assign next_level = walk_level_r + LVL_W'(1);
  assign is_leaf    = req_r.entry_data[PTE_R] || req_r.entry_data[PTE_W_BIT] ||
                      req_r.entry_data[PTE_X] || (walk_level_r >= LAST_LVL);

  // Decode the held request against the walk state
  always_comb begin
    produce                  = 1'b0;
    res                      = '0;
    walk_level_nxt           = walk_level_r;
    held_virtual_address_nxt = held_virtual_address_r;
    walk_busy_nxt            = walk_busy_r;
    case (req_r.kind)
      KIND_TRANSLATE: begin
        // restart from the top, dropping any walk in flight
        produce                  = 1'b1;
        held_virtual_address_nxt = req_r.virtual_address;
        walk_level_nxt           = TOP_LVL;
        walk_busy_nxt            = 1'b1;
        res.result_kind          = RES_READ;
        res.physical_address     = entry_addr(root_base_r, req_r.virtual_address,
                                              level_shift(LEVELS, TOP_LVL)) & PA_MASK;
      end
      KIND_ENTRY: begin
        if (walk_busy_r) begin
          produce = 1'b1;
          if (!req_r.entry_data[PTE_V]) begin
            walk_busy_nxt   = 1'b0;
            res.result_kind = RES_FAULT;
            res.fault_level = walk_level_r;
          end else if (is_leaf) begin
            // superpage: lower VPN fields and offset come from the VA
            walk_busy_nxt        = 1'b0;
            res.result_kind      = RES_DONE;
            res.physical_address = ((ppn_base & ~low_mask) |
                                    (PA_W'(held_virtual_address_r) & low_mask)) & PA_MASK;
          end else begin
            walk_level_nxt       = next_level;
            res.result_kind      = RES_READ;
            res.physical_address = entry_addr(ppn_base, held_virtual_address_r,
                                              level_shift(LEVELS, next_level)) & PA_MASK;
          end
        end
      end
      default: begin
        produce = 1'b0;
      end
    endcase
    // hold state unless the request moves on
    if (!advance) begin
      produce                  = 1'b0;
      walk_level_nxt           = walk_level_r;
      held_virtual_address_nxt = held_virtual_address_r;
      walk_busy_nxt            = walk_busy_r;
    end
  end

  always_comb begin
    req_valid_nxt = in_accept || (req_valid_r && !advance);
    out_valid_nxt = produce || (out_valid_r && out_stall);
    out_data_nxt  = produce ? res : out_data_r;
    root_base_nxt = (cfg_valid && cfg_ready) ? cfg_data : root_base_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r            <= 1'b0;
      out_valid_r            <= 1'b0;
      root_base_r            <= '0;
      walk_level_r           <= '0;
      held_virtual_address_r <= '0;
      walk_busy_r            <= 1'b0;
    end else begin
      req_valid_r            <= req_valid_nxt;
      out_valid_r            <= out_valid_nxt;
      root_base_r            <= root_base_nxt;
      walk_level_r           <= walk_level_nxt;
      held_virtual_address_r <= held_virtual_address_nxt;
      walk_busy_r            <= walk_busy_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/ptw_checker.sv =====
// ----------------------------------------------------------------------------
// ptw_checker: port-level checks for the page table walker
// Watches the result channel for well-formed responses over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_checker
  import ptw_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire ptw_res_t        out_data
);

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled response changed or dropped");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid right after reset");

  a_fault_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == RES_FAULT |-> out_data.physical_address == '0)
    else $error("fault carries an address");

  a_level_only_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind != RES_FAULT |-> out_data.fault_level == '0)
    else $error("fault level set on a non-fault response");

  a_read_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == RES_READ |-> out_data.physical_address[2:0] == 3'b000)
    else $error("entry read not 8-byte aligned");

endmodule

bind three_level_page_table_walker ptw_checker u_ptw_checker (.*);

`default_nettype wire
